// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the HSV to RGB converter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent, checked on every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Expression holds on every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant");

`endif

// ===== hdl/hsvc_pkg.sv =====
`timescale 1ns / 1ps
// Constants and types for the HSV to RGB converter pipeline.
// No dependencies.
package hsvc_pkg;

  localparam int HUE_W   = 15;
  localparam int CHAN_W  = 8;
  localparam int FRAC_W  = 12;
  localparam int PROD_W  = 20;
  localparam int WIDE_W  = 28;

  localparam int unsigned SECTOR_UNITS = 3840;
  localparam int unsigned FULL_SCALE   = 255;
  localparam int unsigned DEN          = SECTOR_UNITS * FULL_SCALE;
  localparam int          MAX_QUOT     = (2 ** HUE_W - 1) / SECTOR_UNITS;

  // floor(n / DEN) = floor((n >> 8) / DIV_REM)
  localparam int unsigned DIV_REM      = DEN / 256;
  localparam int          RECIP_SHIFT  = 32;
  localparam int          RECIP_W      = 21;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_REM);

  typedef enum logic [2:0] {
    SECT_RED_YELLOW    = 3'd0,
    SECT_YELLOW_GREEN  = 3'd1,
    SECT_GREEN_CYAN    = 3'd2,
    SECT_CYAN_BLUE     = 3'd3,
    SECT_BLUE_MAGENTA  = 3'd4,
    SECT_MAGENTA_RED   = 3'd5
  } sector_t;

endpackage

// ===== hdl/hsv_to_rgb_converter_core.sv =====
`timescale 1ns / 1ps
// HSV to RGB converter core: seven-stage pipeline, one pixel per clock.
// Depends on hsvc_pkg and assert_macros.svh.
//
//  channel   handshake         payload
//  -------   ---------------   ------------------------------
//  input     start, busy       hue, saturation, brightness
//  output    done              red, green, blue
//
// A pixel transfers in when start is high and busy is low; busy stays low.
// done rises in the same cycle as the result appears on red, green and blue,
// one per clock when pixels come back to back.
// One register per step sets the latency: sector, product, difference, scale,
// reciprocal, back-multiply, correct and route.
// Reset (synchronous) empties the pipeline; no result can be stalled.
`include "assert_macros.svh"

module hsv_to_rgb_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [14:0] hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);
  import hsvc_pkg::*;

  localparam int LATENCY = 7;
  localparam logic [PROD_W-1:0] DEN_V   = PROD_W'(DEN);
  localparam logic [PROD_W-1:0] DIVR_V  = PROD_W'(DIV_REM);
  localparam logic [PROD_W-1:0] REM_LIM = PROD_W'(2 * DIV_REM);

  function automatic logic [CHAN_W-1:0] div255(input logic [15:0] n);
    logic [16:0] acc;
    acc = 17'(n) + 17'(n[15:8]) + 17'd1;
    return acc[15:8];
  endfunction

  logic [LATENCY-1:0] vld;

  // stage 1: sector and fraction
  logic [3:0]          quot;
  logic [HUE_W-1:0]    base;
  logic [HUE_W-1:0]    fdiff;
  logic [3:0]          sect_raw;
  logic [FRAC_W-1:0]   f1;
  logic [CHAN_W-1:0]   s1, v1;
  sector_t             sect1;

  // stage 2: products
  logic [PROD_W-1:0]   fs2, sfull2;
  logic [15:0]         vs2;
  logic [CHAN_W-1:0]   v2;
  sector_t             sect2;

  // stage 3: differences
  logic [PROD_W-1:0]   mq3, mt3;
  logic [CHAN_W-1:0]   p3, v3;
  sector_t             sect3;

  // stage 4: scaled terms
  logic [WIDE_W-1:0]   nq4, nt4;
  logic [CHAN_W-1:0]   p4, v4;
  sector_t             sect4;

  // stage 5: quotient estimates
  logic [PROD_W+RECIP_W-1:0] rq_prod, rt_prod;
  logic [PROD_W-1:0]   xq5, xt5;
  logic [CHAN_W-1:0]   eq5, et5, p5, v5;
  sector_t             sect5;

  // stage 6: back-multiply
  logic [PROD_W-1:0]   xq6, xt6, bq6, bt6;
  logic [CHAN_W-1:0]   eq6, et6, p6, v6;
  sector_t             sect6;

  // output stage: correct and route
  logic [PROD_W-1:0]   rem_q, rem_t;
  logic [CHAN_W-1:0]   qc, tc;
  logic [CHAN_W-1:0]   red_next, green_next, blue_next;

  assign busy = 1'b0;
  assign done = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
    end
  end

  always_comb begin
    quot = '0;
    base = '0;
    for (int k = 1; k <= MAX_QUOT; k++) begin
      if (hue >= HUE_W'(k * SECTOR_UNITS)) begin
        quot = 4'(k);
        base = HUE_W'(k * SECTOR_UNITS);
      end
    end
    fdiff    = hue - base;
    sect_raw = (quot >= 4'd6) ? quot - 4'd6 : quot;
  end

  always_ff @(posedge clk) begin
    f1    <= fdiff[FRAC_W-1:0];
    sect1 <= sector_t'(sect_raw[2:0]);
    s1    <= saturation;
    v1    <= brightness;
  end

  always_ff @(posedge clk) begin
    fs2    <= PROD_W'(f1) * PROD_W'(s1);
    sfull2 <= PROD_W'(s1) * PROD_W'(SECTOR_UNITS);
    vs2    <= 16'(v1) * 16'(8'(FULL_SCALE) - s1);
    v2     <= v1;
    sect2  <= sect1;
  end

  always_ff @(posedge clk) begin
    mq3   <= DEN_V - fs2;
    mt3   <= DEN_V - (sfull2 - fs2);
    p3    <= div255(vs2);
    v3    <= v2;
    sect3 <= sect2;
  end

  always_ff @(posedge clk) begin
    nq4   <= WIDE_W'(v3) * WIDE_W'(mq3);
    nt4   <= WIDE_W'(v3) * WIDE_W'(mt3);
    p4    <= p3;
    v4    <= v3;
    sect4 <= sect3;
  end

  // reciprocal estimate never overshoots; it may fall one short
  assign rq_prod = (PROD_W+RECIP_W)'(nq4[WIDE_W-1:8]) * (PROD_W+RECIP_W)'(RECIP_M);
  assign rt_prod = (PROD_W+RECIP_W)'(nt4[WIDE_W-1:8]) * (PROD_W+RECIP_W)'(RECIP_M);

  always_ff @(posedge clk) begin
    xq5   <= nq4[WIDE_W-1:8];
    xt5   <= nt4[WIDE_W-1:8];
    eq5   <= rq_prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
    et5   <= rt_prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
    p5    <= p4;
    v5    <= v4;
    sect5 <= sect4;
  end

  always_ff @(posedge clk) begin
    xq6   <= xq5;
    xt6   <= xt5;
    bq6   <= PROD_W'(eq5) * DIVR_V;
    bt6   <= PROD_W'(et5) * DIVR_V;
    eq6   <= eq5;
    et6   <= et5;
    p6    <= p5;
    v6    <= v5;
    sect6 <= sect5;
  end

  always_comb begin
    rem_q = xq6 - bq6;
    rem_t = xt6 - bt6;
    qc    = (rem_q >= DIVR_V) ? eq6 + 8'd1 : eq6;
    tc    = (rem_t >= DIVR_V) ? et6 + 8'd1 : et6;
  end

  always_comb begin
    unique case (sect6)
      SECT_RED_YELLOW: begin
        red_next = v6; green_next = tc; blue_next = p6;
      end
      SECT_YELLOW_GREEN: begin
        red_next = qc; green_next = v6; blue_next = p6;
      end
      SECT_GREEN_CYAN: begin
        red_next = p6; green_next = v6; blue_next = tc;
      end
      SECT_CYAN_BLUE: begin
        red_next = p6; green_next = qc; blue_next = v6;
      end
      SECT_BLUE_MAGENTA: begin
        red_next = tc; green_next = p6; blue_next = v6;
      end
      default: begin
        red_next = v6; green_next = p6; blue_next = qc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

  `ASSERT_IMPL(a_latency, clk, rst, start && !busy, ##7 done)
  `ASSERT_IMPL(a_grey, clk, rst, start && !busy && saturation == 8'd0,
    ##7 (red == $past(brightness, 7) && green == red && blue == red))
  `ASSERT_IMPL(a_rem_bound, clk, rst, vld[LATENCY-2], rem_q < REM_LIM && rem_t < REM_LIM)

endmodule
